// ===== hw/rtl/med2d_pkg.sv =====
package med2d_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PIX_BITS      = 8;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
    localparam int WIDTH_BITS    = 11;
    localparam int HEIGHT_BITS   = 13;
    localparam int TAPS          = 9;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 13;

    typedef logic [PIX_BITS-1:0]            pix_t;
    typedef logic [COL_BITS-1:0]            col_t;
    typedef logic [ROW_BITS-1:0]            row_t;
    typedef logic [WIDTH_BITS-1:0]          width_t;
    typedef logic [HEIGHT_BITS-1:0]         height_t;
    typedef logic [TAPS-1:0][PIX_BITS-1:0]  win_t;

    typedef struct packed {
        logic emit;
        logic interior;
        logic single_row;
        logic last;
    } meta_t;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam width_t  WIDTH_RESET  = width_t'(640);
    localparam height_t HEIGHT_RESET = height_t'(480);
    localparam width_t  WIDTH_MAX    = width_t'(MAX_WIDTH);
    localparam height_t HEIGHT_MAX   = height_t'(MAX_HEIGHT);

    // tap = 3*row + age; row 0 is two lines back, age 0 the newest column
    localparam int TAP_CENTER     = 4;
    localparam int TAP_MID_NEWEST = 3;

    function automatic pix_t median9(input win_t w);
        win_t p;
        pix_t t;
        p = w;
        if (p[1] > p[2]) begin t = p[1]; p[1] = p[2]; p[2] = t; end
        if (p[4] > p[5]) begin t = p[4]; p[4] = p[5]; p[5] = t; end
        if (p[7] > p[8]) begin t = p[7]; p[7] = p[8]; p[8] = t; end
        if (p[0] > p[1]) begin t = p[0]; p[0] = p[1]; p[1] = t; end
        if (p[3] > p[4]) begin t = p[3]; p[3] = p[4]; p[4] = t; end
        if (p[6] > p[7]) begin t = p[6]; p[6] = p[7]; p[7] = t; end
        if (p[1] > p[2]) begin t = p[1]; p[1] = p[2]; p[2] = t; end
        if (p[4] > p[5]) begin t = p[4]; p[4] = p[5]; p[5] = t; end
        if (p[7] > p[8]) begin t = p[7]; p[7] = p[8]; p[8] = t; end
        if (p[0] > p[3]) begin t = p[0]; p[0] = p[3]; p[3] = t; end
        if (p[5] > p[8]) begin t = p[5]; p[5] = p[8]; p[8] = t; end
        if (p[4] > p[7]) begin t = p[4]; p[4] = p[7]; p[7] = t; end
        if (p[3] > p[6]) begin t = p[3]; p[3] = p[6]; p[6] = t; end
        if (p[1] > p[4]) begin t = p[1]; p[1] = p[4]; p[4] = t; end
        if (p[2] > p[5]) begin t = p[2]; p[2] = p[5]; p[5] = t; end
        if (p[4] > p[7]) begin t = p[4]; p[4] = p[7]; p[7] = t; end
        if (p[4] > p[2]) begin t = p[4]; p[4] = p[2]; p[2] = t; end
        if (p[6] > p[4]) begin t = p[6]; p[6] = p[4]; p[4] = t; end
        if (p[4] > p[2]) begin t = p[4]; p[4] = p[2]; p[2] = t; end
        return p[4];
    endfunction

endpackage

// ===== hw/rtl/median_filter_2d.sv =====
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: pixel; tuser: command
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: filtered_pixel; tlast: frame_last
// cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data (always ready)
//
// One beat per cycle in and out while m_axis_tready stays high; the result of a
// triggering beat passes the line store read, the window and then the median output register.
// Reset: 640 x 480, counters cleared; line stores are not cleared, since only
// pixels of the running frame reach a result.
// m_axis_tready low holds the output register, then the window, then the
// input stage; s_axis_tready drops only when the input stage is blocked.
module median_filter_2d (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [med2d_pkg::PIX_BITS-1:0]        s_axis_tdata,  // [7:0] pixel
    input  logic [0:0]                            s_axis_tuser,  // [0] command
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [med2d_pkg::PIX_BITS-1:0]        m_axis_tdata,  // [7:0] filtered_pixel
    output logic                                  m_axis_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [med2d_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [med2d_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import med2d_pkg::*;

    width_t  width_reg;
    height_t height_reg;

    col_t    col_reg, col_next;
    row_t    row_reg, row_next;
    logic    done_reg, done_next;
    col_t    ocol_reg, ocol_next;
    row_t    orow_reg, orow_next;

    logic    s1_valid_reg;
    pix_t    s1_pixel_reg;
    col_t    s1_col_reg;
    meta_t   s1_meta_reg, s1_meta_next;
    pix_t    rd_a_reg, rd_b_reg;
    logic    fwd_reg;
    pix_t    fwd_pix_reg, fwd_rd_a_reg;
    pix_t    rd_a_eff, rd_b_eff;

    logic    s2_valid_reg;
    meta_t   s2_meta_reg;
    win_t    win_reg, win_next;

    logic    out_valid_reg;
    pix_t    out_pixel_reg, out_pixel_next;
    logic    out_last_reg;

    pix_t    line_a_mem [MAX_WIDTH];
    pix_t    line_b_mem [MAX_WIDTH];

    logic    cfg_fire, in_fire, s1_load, s1_move, s2_move, s2_ready, s3_ready;
    logic    act;
    logic    col_wrap, row_wrap, primed;

    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign s3_ready      = !out_valid_reg || m_axis_tready;
    assign s2_move       = s2_valid_reg && s3_ready;
    assign s2_ready      = !s2_valid_reg || s3_ready;
    assign s1_move       = s1_valid_reg && s2_ready;
    assign s_axis_tready = !s1_valid_reg || s2_ready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s1_load       = in_fire && act && !cfg_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:
                begin
                    if (cfg_data[WIDTH_BITS-1:0] == '0)
                        width_reg <= width_t'(1);
                    else if (cfg_data[WIDTH_BITS-1:0] > WIDTH_MAX)
                        width_reg <= WIDTH_MAX;
                    else
                        width_reg <= cfg_data[WIDTH_BITS-1:0];
                end
                CFG_IMAGE_HEIGHT:
                begin
                    if (cfg_data == '0)
                        height_reg <= height_t'(1);
                    else if (cfg_data > HEIGHT_MAX)
                        height_reg <= HEIGHT_MAX;
                    else
                        height_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign col_wrap = ({1'b0, col_reg} + width_t'(1)) == width_reg;
    assign row_wrap = ({1'b0, row_reg} + height_t'(1)) == height_reg;
    // input position has reached one line plus one pixel
    assign primed   = (row_reg >= row_t'(2)) || (row_reg == row_t'(1) && col_reg != '0);

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        done_next    = done_reg;
        ocol_next    = ocol_reg;
        orow_next    = orow_reg;
        act          = 1'b0;
        s1_meta_next = '0;
        if (cfg_fire)
        begin
            col_next  = '0;
            row_next  = '0;
            done_next = 1'b0;
            ocol_next = '0;
            orow_next = '0;
        end
        else if (in_fire)
        begin
            case (s_axis_tuser[0])
                CMD_PIXEL:
                begin
                    if (!done_reg)
                    begin
                        act               = 1'b1;
                        s1_meta_next.emit = primed;
                        col_next          = col_wrap ? '0 : col_reg + col_t'(1);
                        if (col_wrap)
                        begin
                            row_next  = row_wrap ? '0 : row_reg + row_t'(1);
                            done_next = row_wrap;
                        end
                    end
                end
                CMD_DRAIN:
                begin
                    if (done_reg)
                    begin
                        act               = 1'b1;
                        s1_meta_next.emit = 1'b1;
                        col_next          = col_wrap ? '0 : col_reg + col_t'(1);
                    end
                end
                default:
                begin
                end
            endcase
            if (s1_meta_next.emit)
            begin
                s1_meta_next.interior   = orow_reg != '0 && ocol_reg != '0
                    && ({1'b0, orow_reg} + height_t'(1)) < height_reg
                    && ({1'b0, ocol_reg} + width_t'(1)) < width_reg;
                s1_meta_next.single_row = height_reg == height_t'(1);
                s1_meta_next.last       = ({1'b0, orow_reg} + height_t'(1)) == height_reg
                    && ({1'b0, ocol_reg} + width_t'(1)) == width_reg;
                if (({1'b0, ocol_reg} + width_t'(1)) == width_reg)
                begin
                    ocol_next = '0;
                    orow_next = orow_reg + row_t'(1);
                end
                else
                begin
                    ocol_next = ocol_reg + col_t'(1);
                end
                if (s1_meta_next.last)
                begin
                    col_next  = '0;
                    row_next  = '0;
                    done_next = 1'b0;
                    ocol_next = '0;
                    orow_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            done_reg      <= 1'b0;
            ocol_reg      <= '0;
            orow_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            done_reg <= done_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
            if (s1_load)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (s1_move)
                s2_valid_reg <= s1_meta_reg.emit;
            else if (s2_move)
                s2_valid_reg <= 1'b0;
            if (s2_move)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // same column written and read in one cycle only happens back to back
    assign rd_a_eff = fwd_reg ? fwd_pix_reg  : rd_a_reg;
    assign rd_b_eff = fwd_reg ? fwd_rd_a_reg : rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (s1_move)
            line_a_mem[s1_col_reg] <= s1_pixel_reg;
        if (s1_load)
            rd_a_reg <= line_a_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
            line_b_mem[s1_col_reg] <= rd_a_eff;
        if (s1_load)
            rd_b_reg <= line_b_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_pixel_reg <= s_axis_tdata;
            s1_col_reg   <= col_reg;
            s1_meta_reg  <= s1_meta_next;
            fwd_reg      <= s1_move && (s1_col_reg == col_reg);
            fwd_pix_reg  <= s1_pixel_reg;
            fwd_rd_a_reg <= rd_a_eff;
        end
    end

    always_comb
    begin
        win_next    = win_reg;
        win_next[2] = win_reg[1];
        win_next[1] = win_reg[0];
        win_next[0] = rd_b_eff;
        win_next[5] = win_reg[4];
        win_next[4] = win_reg[3];
        win_next[3] = rd_a_eff;
        win_next[8] = win_reg[7];
        win_next[7] = win_reg[6];
        win_next[6] = s1_pixel_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            win_reg     <= win_next;
            s2_meta_reg <= s1_meta_reg;
        end
    end

    // a single-line frame drains one pixel earlier than the window center
    always_comb
    begin
        if (s2_meta_reg.interior)
            out_pixel_next = median9(win_reg);
        else if (s2_meta_reg.single_row)
            out_pixel_next = win_reg[TAP_MID_NEWEST];
        else
            out_pixel_next = win_reg[TAP_CENTER];
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            out_pixel_reg <= out_pixel_next;
            out_last_reg  <= s2_meta_reg.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pixel_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_done_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> row_reg == '0)
        else $error("row count not cleared after last input line");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        s1_load && s1_meta_next.last |=> col_reg == '0 && !done_reg && ocol_reg == '0)
        else $error("frame not restarted after final result");

    a_window_held: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s3_ready |=> s2_valid_reg && $stable(win_reg))
        else $error("window moved under a pending result");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    import med2d_pkg::*;

    localparam int HISTORY_DEPTH = 2 * MAX_WIDTH + 3;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 650;
    localparam int WIDE_PIXELS   = 1100;
    localparam int MAX_REPORTS   = 100;
    localparam int SCRIPT_LEN    = 25;

    typedef struct packed {
        pix_t value;
        logic last;
    } out_pixel_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_BEAT, ROW_KNOWN} row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_IDX_BITS-1:0]  reg_index;
        logic [CFG_DATA_BITS-1:0] reg_value;
        logic                     cmd;
        pix_t                     pixel;
        logic                     has_out;
        pix_t                     out_value;
        logic                     out_last;
    } script_row_t;

    // 1x1 frame, then a 3x3 frame of extremes whose center median is 0x80
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_DRAIN, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG,   CFG_IMAGE_WIDTH,  13'd0, CMD_PIXEL, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG,   CFG_IMAGE_HEIGHT, 13'd0, CMD_PIXEL, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_PIXEL, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_PIXEL, 8'h11, 1'b0, 8'h00, 1'b0},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_DRAIN, 8'h00, 1'b1, 8'hFF, 1'b1},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_DRAIN, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG,   CFG_IMAGE_WIDTH,  13'd3, CMD_PIXEL, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG,   CFG_IMAGE_HEIGHT, 13'd3, CMD_PIXEL, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_PIXEL, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_PIXEL, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_DRAIN, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_PIXEL, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_PIXEL, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_PIXEL, 8'h80, 1'b1, 8'hFF, 1'b0},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_PIXEL, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_PIXEL, 8'hFF, 1'b1, 8'hFF, 1'b0},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_PIXEL, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_PIXEL, 8'hFF, 1'b1, 8'h80, 1'b0},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_PIXEL, 8'h5A, 1'b0, 8'h00, 1'b0},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_DRAIN, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_DRAIN, 8'h00, 1'b1, 8'hFF, 1'b0},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_DRAIN, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0, CMD_DRAIN, 8'h00, 1'b1, 8'hFF, 1'b1},
        '{ROW_BEAT,  CFG_IMAGE_WIDTH,  13'd0, CMD_PIXEL, 8'h3C, 1'b0, 8'h00, 1'b0}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    pix_t                     s_axis_tdata;
    logic [0:0]               s_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    pix_t                     m_axis_tdata;
    logic                     m_axis_tlast;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    pix_t        pixel_history [HISTORY_DEPTH];
    width_t      width_reg;
    height_t     height_reg;
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned out_pos;
    bit          frame_loaded;

    out_pixel_t  pending_pixels [$];
    out_pixel_t  head;
    int unsigned errors = 0;
    int unsigned out_beats = 0;
    int unsigned live_items = 0;
    int unsigned stall_cycles = 0;
    int unsigned tx_gap_pct = 0;
    int unsigned rx_stall_pct = 0;

    median_filter_2d DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int unsigned frame_width();
        int unsigned w;
        w = 32'(width_reg);
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned frame_height();
        int unsigned h;
        h = 32'(height_reg);
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic void restart_frame();
        col_pos = 0;
        row_pos = 0;
        out_pos = 0;
        frame_loaded = 1'b0;
    endfunction

    function automatic out_pixel_t emit_pixel();
        int unsigned w, h, o, r, c, dr, dc;
        int          i, j;
        pix_t        taps [9];
        pix_t        t;
        out_pixel_t  res;
        w = frame_width();
        h = frame_height();
        o = out_pos;
        r = o / w;
        c = o % w;
        if (r >= 1 && r + 1 < h && c >= 1 && c + 1 < w)
        begin
            for (dr = 0; dr < 3; dr++)
            begin
                for (dc = 0; dc < 3; dc++)
                    taps[3 * dr + dc] = pixel_history[((r + dr - 1) * w + c + dc - 1)
                                                      % HISTORY_DEPTH];
            end
            for (i = 1; i < 9; i++)
            begin
                t = taps[i];
                j = i - 1;
                while (j >= 0 && taps[j] > t)
                begin
                    taps[j + 1] = taps[j];
                    j--;
                end
                taps[j + 1] = t;
            end
            res.value = taps[4];
        end
        else
            res.value = pixel_history[o % HISTORY_DEPTH];
        res.last = (o == w * h - 1);
        out_pos = o + 1;
        if (res.last)
            restart_frame();
        return res;
    endfunction

    function automatic bit filter_beat(input logic cmd, input pix_t pix,
                                       output out_pixel_t res);
        int unsigned w, h, k;
        w = frame_width();
        h = frame_height();
        if (cmd == CMD_DRAIN)
        begin
            if (!frame_loaded || out_pos >= w * h)
                return 1'b0;
            res = emit_pixel();
            return 1'b1;
        end
        if (frame_loaded)
            return 1'b0;
        k = row_pos * w + col_pos;
        pixel_history[k % HISTORY_DEPTH] = pix;
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
            begin
                row_pos = 0;
                frame_loaded = 1'b1;
            end
        end
        if (k >= w + 1)
        begin
            res = emit_pixel();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic pix_t random_pixel();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return pix_t'($urandom);
        endcase
    endfunction

    task automatic set_idling(input int unsigned mode);
        case (mode)
            0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_gap_pct = 69; rx_stall_pct = 0;  end
            2: begin tx_gap_pct = 0;  rx_stall_pct = 69; end
            default: begin tx_gap_pct = 31; rx_stall_pct = 31; end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic send_beat(input logic cmd, input pix_t pix, input bit typed = 1'b0,
                             input bit typed_has = 1'b0, input out_pixel_t typed_res = '0);
        bit         produced;
        out_pixel_t res;
        while ($urandom_range(99) < tx_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= pix;
        do @(posedge clk); while (!s_axis_tready);
        if ((cmd == CMD_PIXEL) ? !frame_loaded : frame_loaded)
            live_items++;
        produced = filter_beat(cmd, pix, res);
        if (typed)
        begin
            produced = typed_has;
            res = typed_res;
        end
        if (produced)
            pending_pixels = {pending_pixels, res};
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_pixels.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH)
            width_reg = value[WIDTH_BITS-1:0];
        else
            height_reg = value[HEIGHT_BITS-1:0];
        restart_frame();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            out_beats++;
            if (pending_pixels.size() == 0)
                report_mismatch($sformatf("beat %0d unexpected: data %0h last %0b",
                                          out_beats, m_axis_tdata, m_axis_tlast));
            else
            begin
                head = pending_pixels.pop_front();
                if (m_axis_tdata !== head.value)
                    report_mismatch($sformatf("beat %0d: data %0h, expected %0h",
                                              out_beats, m_axis_tdata, head.value));
                if (m_axis_tlast !== head.last)
                    report_mismatch($sformatf("beat %0d: last %0b, expected %0b",
                                              out_beats, m_axis_tlast, head.last));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int unsigned              w_pick, h_pick, remaining, budget;
        int unsigned              drain_cap, drained, phase, start_items;
        logic [CFG_DATA_BITS-1:0] wdata;
        clk = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_PIXEL;
        m_axis_tready <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_IMAGE_WIDTH;
        cfg_data      <= '0;
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        restart_frame();
        set_idling(3);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            if (SCRIPT[i].kind == ROW_CFG)
                write_register(SCRIPT[i].reg_index, SCRIPT[i].reg_value);
            else
                send_beat(SCRIPT[i].cmd, SCRIPT[i].pixel, SCRIPT[i].kind == ROW_KNOWN,
                          SCRIPT[i].has_out, {SCRIPT[i].out_value, SCRIPT[i].out_last});
        end

        // widest line, clamped from all-ones registers; aborted early in line two
        set_idling(2);
        write_register(CFG_IMAGE_WIDTH, 13'h07FF);
        write_register(CFG_IMAGE_HEIGHT, 13'h1FFF);
        repeat (WIDE_PIXELS) send_beat(CMD_PIXEL, random_pixel());

        start_items = live_items;
        phase = 0;
        while (live_items - start_items < RANDOM_ITEMS)
        begin
            set_idling(phase % 4);
            phase++;
            if ($urandom_range(7) != 0)
            begin
                case ($urandom_range(9))
                    0:
                        case ($urandom_range(6))
                            0: w_pick = 0;
                            1: w_pick = 1;
                            2: w_pick = 2;
                            3: w_pick = 3;
                            4: w_pick = 1023;
                            5: w_pick = 1024;
                            default: w_pick = 2047;
                        endcase
                    1: w_pick = $urandom_range(0, 2047);
                    default: w_pick = $urandom_range(1, 12);
                endcase
                wdata = CFG_DATA_BITS'(w_pick);
                if ($urandom_range(1) != 0)
                    wdata[CFG_DATA_BITS-1:WIDTH_BITS] = 2'($urandom_range(3));
                write_register(CFG_IMAGE_WIDTH, wdata);
            end
            if ($urandom_range(7) != 0)
            begin
                case ($urandom_range(9))
                    0:
                        case ($urandom_range(6))
                            0: h_pick = 0;
                            1: h_pick = 1;
                            2: h_pick = 2;
                            3: h_pick = 3;
                            4: h_pick = 4095;
                            5: h_pick = 4096;
                            default: h_pick = 8191;
                        endcase
                    1: h_pick = $urandom_range(0, 8191);
                    default: h_pick = $urandom_range(1, 8);
                endcase
                write_register(CFG_IMAGE_HEIGHT, CFG_DATA_BITS'(h_pick));
            end

            remaining = frame_loaded ? 0 : frame_width() * frame_height()
                                           - (row_pos * frame_width() + col_pos);
            if (remaining <= 120 && $urandom_range(9) != 0)
                budget = remaining;
            else
                budget = $urandom_range(1, remaining < 150 ? remaining : 150);
            for (int n = 0; n < budget && !frame_loaded; n++)
            begin
                if ($urandom_range(24) == 0)
                    send_beat(CMD_DRAIN, random_pixel());
                send_beat(CMD_PIXEL, random_pixel());
                if ($urandom_range(79) == 0)
                    wait_for_results();
            end
            if (frame_loaded && $urandom_range(3) == 0)
                repeat ($urandom_range(1, 3)) send_beat(CMD_PIXEL, random_pixel());
            drain_cap = ($urandom_range(7) == 0) ? $urandom_range(20) : 32'hFFFF_FFFF;
            drained = 0;
            while (frame_loaded && drained < drain_cap)
            begin
                send_beat(CMD_DRAIN, random_pixel());
                drained++;
            end
        end

        wait_for_results();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending_pixels.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/med2d_pkg.sv
hw/rtl/median_filter_2d.sv
tb/sv/testbench.sv
